[hdl/brrp_pkg.sv]
// Shared constants, types and codes for the bilinear RGB remap pixel unit.
package brrp_pkg;

    // Coordinate format and source size limit.
    localparam int COORD_FRAC_BITS = 8;
    localparam int MAX_SOURCE_DIM  = 4096;

    // Field widths fixed by the pixel interface.
    localparam int COORD_W   = 20;
    localparam int PIX_W     = 24;
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 3;
    localparam int NUM_NBR   = 4;
    localparam int CFG_DIM_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Weight format: 16 fraction bits, values 0 to 1.0 inclusive.
    localparam int W_FRAC    = 16;
    localparam int WEIGHT_W  = W_FRAC + 1;
    localparam int PROD_W    = 2 * WEIGHT_W;
    localparam int TERM_PROD_W = CHAN_W + WEIGHT_W;
    localparam int SUM_W     = CHAN_W + 2;
    localparam logic [WEIGHT_W-1:0] ONE_WEIGHT = WEIGHT_W'(1) << W_FRAC;
    localparam int FRAC_SHIFT = W_FRAC - COORD_FRAC_BITS;

    // Integer part of a coordinate and the width used for the bound compare.
    localparam int INT_W   = COORD_W - COORD_FRAC_BITS;
    localparam int DIM_W   = $clog2(MAX_SOURCE_DIM + 1);
    localparam int CMP_A_W = (INT_W + 1 > DIM_W) ? INT_W + 1 : DIM_W;
    localparam int CMP_W   = ((CMP_A_W > CFG_DIM_W) ? CMP_A_W : CFG_DIM_W) + 1;

    // Neighbor order within the packed arrays.
    localparam int NBR_TL = 0;
    localparam int NBR_TR = 1;
    localparam int NBR_BL = 2;
    localparam int NBR_BR = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_COLOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_COLOR = 3'd4;

    // Pixel kind tag.
    typedef enum logic [1:0] {
        KIND_VALID  = 2'd0,
        KIND_BORDER = 2'd1,
        KIND_BLANK  = 2'd2,
        KIND_BLACK  = 2'd3
    } t_kind;

    // Configuration register file contents.
    typedef struct packed {
        logic [CFG_DIM_W-1:0] src_width;
        logic [CFG_DIM_W-1:0] src_height;
        logic                 byte_order;
        logic [PIX_W-1:0]     border_color;
        logic [PIX_W-1:0]     blank_color;
    } t_cfg;

    // Stage one: fractional weights and neighbor use flags.
    typedef struct packed {
        t_kind                           kind;
        logic                            frame_end;
        logic [WEIGHT_W-1:0]             fx;
        logic [WEIGHT_W-1:0]             fy;
        logic [WEIGHT_W-1:0]             wx1;
        logic [WEIGHT_W-1:0]             wy1;
        logic                            use_right;
        logic                            use_lower;
        logic [NUM_NBR-1:0][PIX_W-1:0]   pix;
    } t_frac;

    // Stage two: one weight per neighbor, zero where the neighbor is skipped.
    typedef struct packed {
        t_kind                           kind;
        logic                            frame_end;
        logic [NUM_NBR-1:0][WEIGHT_W-1:0] w;
        logic [NUM_NBR-1:0][PIX_W-1:0]   pix;
    } t_wgt;

    // Stage three: truncated weighted channel terms.
    typedef struct packed {
        t_kind                                       kind;
        logic                                        frame_end;
        logic [NUM_NBR-1:0][NUM_CHAN-1:0][CHAN_W-1:0] term;
    } t_term;

endpackage

[hdl/brrp_weight.sv]
// Fraction extraction, bound checks and neighbor weight multipliers (two stages).
module brrp_weight (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  brrp_pkg::t_cfg                     i_cfg,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  brrp_pkg::t_kind                    i_kind,
    input  logic [brrp_pkg::COORD_W-1:0]       i_coord_x,
    input  logic [brrp_pkg::COORD_W-1:0]       i_coord_y,
    input  logic [brrp_pkg::NUM_NBR-1:0][brrp_pkg::PIX_W-1:0] i_pix,
    input  logic                               i_frame_end,
    output logic                               o_valid,
    input  logic                               i_ready,
    output brrp_pkg::t_wgt                     o_wgt
);

    logic                 r_v1;
    brrp_pkg::t_frac      r_s1;
    brrp_pkg::t_frac      n_s1;
    logic                 r_v2;
    brrp_pkg::t_wgt       r_s2;
    brrp_pkg::t_wgt       n_s2;
    logic                 s1_ready;
    logic                 s2_ready;

    logic [brrp_pkg::INT_W-1:0]           ix;
    logic [brrp_pkg::INT_W-1:0]           iy;
    logic [brrp_pkg::COORD_FRAC_BITS-1:0] frac_x;
    logic [brrp_pkg::COORD_FRAC_BITS-1:0] frac_y;
    logic [brrp_pkg::CMP_W-1:0]           sat_w;
    logic [brrp_pkg::CMP_W-1:0]           sat_h;
    logic [brrp_pkg::PROD_W-1:0]          prod [brrp_pkg::NUM_NBR];

    // Each stage moves when it is empty or its contents move on.
    assign s2_ready = !r_v2 || i_ready;
    assign s1_ready = !r_v1 || s2_ready;
    assign o_ready  = s1_ready;

    // Effective source size, limited to the largest supported dimension.
    always_comb begin
        if (brrp_pkg::CMP_W'(i_cfg.src_width) > brrp_pkg::CMP_W'(brrp_pkg::MAX_SOURCE_DIM)) begin
            sat_w = brrp_pkg::CMP_W'(brrp_pkg::MAX_SOURCE_DIM);
        end else begin
            sat_w = brrp_pkg::CMP_W'(i_cfg.src_width);
        end
        if (brrp_pkg::CMP_W'(i_cfg.src_height) > brrp_pkg::CMP_W'(brrp_pkg::MAX_SOURCE_DIM)) begin
            sat_h = brrp_pkg::CMP_W'(brrp_pkg::MAX_SOURCE_DIM);
        end else begin
            sat_h = brrp_pkg::CMP_W'(i_cfg.src_height);
        end
    end

    // Stage one: split the coordinates, form the four axis weights and use flags.
    always_comb begin
        ix     = i_coord_x[brrp_pkg::COORD_W-1:brrp_pkg::COORD_FRAC_BITS];
        iy     = i_coord_y[brrp_pkg::COORD_W-1:brrp_pkg::COORD_FRAC_BITS];
        frac_x = i_coord_x[brrp_pkg::COORD_FRAC_BITS-1:0];
        frac_y = i_coord_y[brrp_pkg::COORD_FRAC_BITS-1:0];
        n_s1.kind      = i_kind;
        n_s1.frame_end = i_frame_end;
        n_s1.fx  = brrp_pkg::WEIGHT_W'(frac_x) << brrp_pkg::FRAC_SHIFT;
        n_s1.fy  = brrp_pkg::WEIGHT_W'(frac_y) << brrp_pkg::FRAC_SHIFT;
        n_s1.wx1 = brrp_pkg::ONE_WEIGHT - n_s1.fx;
        n_s1.wy1 = brrp_pkg::ONE_WEIGHT - n_s1.fy;
        n_s1.use_right = (frac_x != '0) &&
                         (brrp_pkg::CMP_W'(ix) + brrp_pkg::CMP_W'(1) < sat_w);
        n_s1.use_lower = (frac_y != '0) &&
                         (brrp_pkg::CMP_W'(iy) + brrp_pkg::CMP_W'(1) < sat_h);
        n_s1.pix = i_pix;
    end

    // Stage two: neighbor weights as products of the axis weights.
    always_comb begin
        prod[brrp_pkg::NBR_TL] = brrp_pkg::PROD_W'(r_s1.wx1) * brrp_pkg::PROD_W'(r_s1.wy1);
        prod[brrp_pkg::NBR_TR] = brrp_pkg::PROD_W'(r_s1.fx)  * brrp_pkg::PROD_W'(r_s1.wy1);
        prod[brrp_pkg::NBR_BL] = brrp_pkg::PROD_W'(r_s1.wx1) * brrp_pkg::PROD_W'(r_s1.fy);
        prod[brrp_pkg::NBR_BR] = brrp_pkg::PROD_W'(r_s1.fx)  * brrp_pkg::PROD_W'(r_s1.fy);
        n_s2.kind      = r_s1.kind;
        n_s2.frame_end = r_s1.frame_end;
        n_s2.pix       = r_s1.pix;
        n_s2.w[brrp_pkg::NBR_TL] = prod[brrp_pkg::NBR_TL][brrp_pkg::W_FRAC +: brrp_pkg::WEIGHT_W];
        n_s2.w[brrp_pkg::NBR_TR] = r_s1.use_right ?
            prod[brrp_pkg::NBR_TR][brrp_pkg::W_FRAC +: brrp_pkg::WEIGHT_W] : '0;
        n_s2.w[brrp_pkg::NBR_BL] = r_s1.use_lower ?
            prod[brrp_pkg::NBR_BL][brrp_pkg::W_FRAC +: brrp_pkg::WEIGHT_W] : '0;
        n_s2.w[brrp_pkg::NBR_BR] = (r_s1.use_right && r_s1.use_lower) ?
            prod[brrp_pkg::NBR_BR][brrp_pkg::W_FRAC +: brrp_pkg::WEIGHT_W] : '0;
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_valid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Stage payloads, loaded only with a transfer into the stage.
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1 <= n_s1;
        end
        if (s2_ready && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_wgt   = r_s2;

`ifndef NO_ASSERTIONS
    // A right neighbor flagged as skipped never carries weight into stage two.
    a_skip_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_ready && r_v1 && !r_s1.use_right) |=>
            (r_s2.w[brrp_pkg::NBR_TR] == '0 && r_s2.w[brrp_pkg::NBR_BR] == '0))
        else $error("skipped right neighbor has nonzero weight");

    // A stalled stage two holds its item.
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !i_ready) |=> (r_v2 && $stable(r_s2)))
        else $error("stage two item changed while stalled");
`endif

endmodule

[hdl/brrp_term.sv]
// Channel term multipliers: each channel of each neighbor times its weight.
module brrp_term (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  brrp_pkg::t_wgt  i_wgt,
    output logic            o_valid,
    input  logic            i_ready,
    output brrp_pkg::t_term o_term
);

    logic                                 r_v;
    brrp_pkg::t_term                      r_s;
    brrp_pkg::t_term                      n_s;
    logic [brrp_pkg::TERM_PROD_W-1:0]     prod [brrp_pkg::NUM_NBR][brrp_pkg::NUM_CHAN];

    assign o_ready = !r_v || i_ready;

    // Twelve independent products, each truncated to its integer part.
    always_comb begin
        n_s.kind      = i_wgt.kind;
        n_s.frame_end = i_wgt.frame_end;
        for (int n = 0; n < brrp_pkg::NUM_NBR; n++) begin
            for (int k = 0; k < brrp_pkg::NUM_CHAN; k++) begin
                prod[n][k] = brrp_pkg::TERM_PROD_W'(
                                 i_wgt.pix[n][k*brrp_pkg::CHAN_W +: brrp_pkg::CHAN_W])
                           * brrp_pkg::TERM_PROD_W'(i_wgt.w[n]);
                n_s.term[n][k] = prod[n][k][brrp_pkg::W_FRAC +: brrp_pkg::CHAN_W];
            end
        end
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s <= n_s;
        end
    end

    assign o_valid = r_v;
    assign o_term  = r_s;

endmodule

[hdl/brrp_blend.sv]
// Term summation, color selection by kind and byte ordering into the output register.
module brrp_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brrp_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  brrp_pkg::t_term               i_term,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [brrp_pkg::CHAN_W-1:0]   o_first,
    output logic [brrp_pkg::CHAN_W-1:0]   o_second,
    output logic [brrp_pkg::CHAN_W-1:0]   o_third,
    output logic                          o_frame_done
);

    logic                                          r_v;
    logic [brrp_pkg::NUM_CHAN-1:0][brrp_pkg::CHAN_W-1:0] r_out;
    logic [brrp_pkg::NUM_CHAN-1:0][brrp_pkg::CHAN_W-1:0] n_out;
    logic                                          r_frame_done;
    logic [brrp_pkg::SUM_W-1:0]                    sum [brrp_pkg::NUM_CHAN];
    logic [brrp_pkg::NUM_CHAN-1:0][brrp_pkg::CHAN_W-1:0] rgb;

    assign o_ready = !r_v || i_ready;

    // Per-channel sum of the four neighbor terms.
    always_comb begin
        for (int k = 0; k < brrp_pkg::NUM_CHAN; k++) begin
            sum[k] = '0;
            for (int n = 0; n < brrp_pkg::NUM_NBR; n++) begin
                sum[k] = sum[k] + brrp_pkg::SUM_W'(i_term.term[n][k]);
            end
        end
    end

    // Color by pixel kind, then channel order.
    always_comb begin
        case (i_term.kind)
            brrp_pkg::KIND_VALID: begin
                for (int k = 0; k < brrp_pkg::NUM_CHAN; k++) begin
                    rgb[k] = sum[k][brrp_pkg::CHAN_W-1:0];
                end
            end
            brrp_pkg::KIND_BORDER: rgb = i_cfg.border_color;
            brrp_pkg::KIND_BLANK:  rgb = i_cfg.blank_color;
            default:               rgb = '0;
        endcase
        n_out[1] = rgb[1];
        if (i_cfg.byte_order) begin
            n_out[0] = rgb[2];
            n_out[2] = rgb[0];
        end else begin
            n_out[0] = rgb[0];
            n_out[2] = rgb[2];
        end
    end

    // Output valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out        <= n_out;
            r_frame_done <= i_term.frame_end;
        end
    end

    assign o_valid      = r_v;
    assign o_first      = r_out[0];
    assign o_second     = r_out[1];
    assign o_third      = r_out[2];
    assign o_frame_done = r_frame_done;

`ifndef NO_ASSERTIONS
    // Truncated terms of a valid pixel never add up past one byte.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_term.kind == brrp_pkg::KIND_VALID) |->
            (sum[0][brrp_pkg::SUM_W-1:brrp_pkg::CHAN_W] == '0 &&
             sum[1][brrp_pkg::SUM_W-1:brrp_pkg::CHAN_W] == '0 &&
             sum[2][brrp_pkg::SUM_W-1:brrp_pkg::CHAN_W] == '0))
        else $error("channel sum exceeds one byte");
`endif

endmodule

[hdl/bilinear_rgb_remap_pixel_unit.sv]
// Top level of the bilinear RGB remap pixel unit: configuration registers and pipeline.
//
// Takes one pixel request per clock cycle unless a stall at the output has filled every stage,
// and returns one output pixel per request, in order. The work runs through four register
// stages: coordinate split and bound checks, the 17 by 17 bit neighbor weight
// multipliers, the twelve channel term multipliers, and the term sum with color and
// byte order selection into the output register. A stall at the output backs up stage
// by stage; the unit keeps taking requests until every stage holds one. Configuration
// writes take effect in the next cycle and are meant to be made while no pixel is in
// flight. There is no initialization pass after reset.
module bilinear_rgb_remap_pixel_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [brrp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [brrp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_pixel_kind,
    input  logic [brrp_pkg::COORD_W-1:0]      i_coord_x,
    input  logic [brrp_pkg::COORD_W-1:0]      i_coord_y,
    input  logic [brrp_pkg::PIX_W-1:0]        i_pix_top_left,
    input  logic [brrp_pkg::PIX_W-1:0]        i_pix_top_right,
    input  logic [brrp_pkg::PIX_W-1:0]        i_pix_bottom_left,
    input  logic [brrp_pkg::PIX_W-1:0]        i_pix_bottom_right,
    input  logic                              i_frame_end,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [brrp_pkg::CHAN_W-1:0]       o_out_first,
    output logic [brrp_pkg::CHAN_W-1:0]       o_out_second,
    output logic [brrp_pkg::CHAN_W-1:0]       o_out_third,
    output logic                              o_frame_done
);

    brrp_pkg::t_cfg  r_cfg;
    logic [brrp_pkg::NUM_NBR-1:0][brrp_pkg::PIX_W-1:0] pix;
    logic            wgt_valid;
    logic            wgt_ready;
    brrp_pkg::t_wgt  wgt;
    logic            term_valid;
    logic            term_ready;
    brrp_pkg::t_term term;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width    <= brrp_pkg::CFG_DIM_W'(640);
            r_cfg.src_height   <= brrp_pkg::CFG_DIM_W'(480);
            r_cfg.byte_order   <= 1'b0;
            r_cfg.border_color <= '0;
            r_cfg.blank_color  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                brrp_pkg::CFG_SRC_WIDTH:    r_cfg.src_width  <= i_cfg_data[brrp_pkg::CFG_DIM_W-1:0];
                brrp_pkg::CFG_SRC_HEIGHT:   r_cfg.src_height <= i_cfg_data[brrp_pkg::CFG_DIM_W-1:0];
                brrp_pkg::CFG_BYTE_ORDER:   r_cfg.byte_order <= i_cfg_data[0];
                brrp_pkg::CFG_BORDER_COLOR: r_cfg.border_color <= i_cfg_data[brrp_pkg::PIX_W-1:0];
                brrp_pkg::CFG_BLANK_COLOR:  r_cfg.blank_color  <= i_cfg_data[brrp_pkg::PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Neighbor pixels in the pipeline's neighbor order.
    always_comb begin
        pix[brrp_pkg::NBR_TL] = i_pix_top_left;
        pix[brrp_pkg::NBR_TR] = i_pix_top_right;
        pix[brrp_pkg::NBR_BL] = i_pix_bottom_left;
        pix[brrp_pkg::NBR_BR] = i_pix_bottom_right;
    end

    brrp_weight u_weight (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (brrp_pkg::t_kind'(i_pixel_kind)),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_pix       (pix),
        .i_frame_end (i_frame_end),
        .o_valid     (wgt_valid),
        .i_ready     (wgt_ready),
        .o_wgt       (wgt)
    );

    brrp_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (wgt_valid),
        .o_ready (wgt_ready),
        .i_wgt   (wgt),
        .o_valid (term_valid),
        .i_ready (term_ready),
        .o_term  (term)
    );

    brrp_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (term_valid),
        .o_ready      (term_ready),
        .i_term       (term),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_first      (o_out_first),
        .o_second     (o_out_second),
        .o_third      (o_out_third),
        .o_frame_done (o_frame_done)
    );

`ifndef NO_ASSERTIONS
    // With the output register empty the whole pipeline can take a transfer.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output register is empty");

    // A transfer taken while the pipeline drains freely reaches the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_ready) ##1 i_ready ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("pixel did not reach the output in four cycles");
`endif

endmodule
